// ----- design/edcr_pkg.sv -----
package edcr_pkg;

  // working width for rounding and saturation helpers
  localparam int RW = 72;

  // digit-by-digit square root: 64-bit radicand, 32-bit root, one bit per stage
  localparam int SQ_IN_W  = 64;
  localparam int SQ_OUT_W = 32;
  localparam int SQ_STEPS = SQ_OUT_W;

  // restoring divider: quotient known to stay below 2^DIV_Q_W
  localparam int DIV_NUM_W = 63;
  localparam int DIV_DEN_W = 33;
  localparam int DIV_Q_W   = 31;

  localparam logic signed [RW-1:0] S32_MAX = (RW'(1) <<< 31) - 1;
  localparam logic signed [RW-1:0] S32_MIN = -(RW'(1) <<< 31);
  localparam logic signed [40:0]   N_LIM   = 41'(1) <<< 32;

  typedef enum logic [1:0] {
    OUT_RESOLVED   = 2'd0,
    OUT_COINCIDENT = 2'd1,
    OUT_ZERO_MASS  = 2'd2
  } outcome_e;

  // round v / 2^sh half away from zero
  function automatic logic signed [RW-1:0] rshr(input logic signed [RW-1:0] v, input int sh);
    logic signed [RW-1:0] h;
    logic signed [RW-1:0] t;
    h = RW'(1) <<< (sh - 1);
    t = v + h;
    if (v[RW-1]) t = t - 1;
    return t >>> sh;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [RW-1:0] v);
    logic signed [RW-1:0] c;
    c = v;
    if (v > S32_MAX) c = S32_MAX;
    if (v < S32_MIN) c = S32_MIN;
    return 32'(c);
  endfunction

  // limit a new normal speed to +-2^32 lsb
  function automatic logic signed [33:0] clampn(input logic signed [40:0] v);
    logic signed [40:0] c;
    c = v;
    if (v > N_LIM) c = N_LIM;
    if (v < -N_LIM) c = -N_LIM;
    return 34'(c);
  endfunction

endpackage

// ----- design/elastic_disk_collision_response.sv -----
// Elastic collision of two disks: separates overlapping disks along the centre
// line and swaps their normal velocity parts by the 1-D elastic rule, mass being
// radius squared, all in saturating fixed point. The block takes one disk pair
// per clock while the skid stage is empty; each result passes the front stages,
// the 32-step square root and the 31-step divider that forms the unit normal
// and mass shares, each cut one bit per stage, and the back stages. An output
// register with a skid stage behind it decouples the two channels, so
// in_ready_o is a plain register and a stalled output loses nothing.
module elastic_disk_collision_response import edcr_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] a_pos_x_i,
  input  logic signed [31:0] a_pos_y_i,
  input  logic signed [31:0] b_pos_x_i,
  input  logic signed [31:0] b_pos_y_i,
  input  logic signed [31:0] a_vel_x_i,
  input  logic signed [31:0] a_vel_y_i,
  input  logic signed [31:0] b_vel_x_i,
  input  logic signed [31:0] b_vel_y_i,
  input  logic        [15:0] a_radius_i,
  input  logic        [15:0] b_radius_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] new_a_pos_x_o,
  output logic signed [31:0] new_a_pos_y_o,
  output logic signed [31:0] new_b_pos_x_o,
  output logic signed [31:0] new_b_pos_y_o,
  output logic signed [31:0] new_a_vel_x_o,
  output logic signed [31:0] new_a_vel_y_o,
  output logic signed [31:0] new_b_vel_x_o,
  output logic signed [31:0] new_b_vel_y_o,
  output logic               pushed_apart_o,
  output logic        [1:0]  outcome_o
);

  // all working values of one pair; each stage fills in its own part
  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by, vax, vay, vbx, vby;
    logic [15:0]        ra, rb;
    logic               dx_neg, dy_neg, coin, far, zm, pa;
    logic [32:0]        ux, uy;
    logic [31:0]        sx, sy;
    logic [61:0]        ux2, uy2;
    logic [62:0]        dsum;
    logic [63:0]        sx2, sy2, lsum;
    logic [31:0]        ma, mb;
    logic [32:0]        mt;
    logic [31:0]        len;
    logic [24:0]        ov;
    logic [62:0]        num_x, num_y, num_a, num_b;
    logic signed [31:0] nx, ny;
    logic [30:0]        ca, cb;
    logic signed [57:0] ppx, ppy;
    logic signed [63:0] p_axn, p_ayn, p_ayx, p_axy, p_bxn, p_byn, p_byx, p_bxy;
    logic signed [64:0] sum_an, sum_at, sum_bn, sum_bt;
    logic signed [25:0] px, py;
    logic signed [33:0] nax, nay, nbx, nby;
    logic signed [34:0] van, vat, vbn, vbt;
    logic signed [35:0] dba, dab;
    logic signed [67:0] ta, tb;
    logic signed [39:0] ea, eb;
    logic signed [33:0] nan, nbn;
    logic signed [66:0] qa1, qa2, qa3, qa4, qb1, qb2, qb3, qb4;
    logic signed [67:0] wsax, wsay, wsbx, wsby;
    logic signed [37:0] wax, way, wbx, wby;
  } pipe_t;

  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by, vax, vay, vbx, vby;
    logic               pa;
    outcome_e           outcome;
  } res_t;

  localparam int BACK_STAGES = 12;

  // stage enable: the whole pipe moves unless the skid stage holds a result
  logic en;
  logic out_take;

  // front stages, root delay line, normal set-up, divider delay line, back stages
  pipe_t s1_q, s1_d, s2_q, s2_d, s3_q, s3_d, s4_q, s4_d;
  pipe_t sq_dl_q [SQ_STEPS];
  pipe_t s5_q, s5_d;
  pipe_t dv_dl_q [DIV_Q_W];
  pipe_t s6_q, s6_d, s7_q, s7_d, s8_q, s8_d, s9_q, s9_d, s10_q, s10_d;
  pipe_t s11_q, s11_d, s12_q, s12_d, s13_q, s13_d, s14_q, s14_d, s15_q, s15_d;
  pipe_t s16_q, s16_d;
  res_t  s17_q, s17_d;
  res_t  out_q, skid_q;

  logic [3:0]             vf_q;
  logic [SQ_STEPS-1:0]    vsq_q;
  logic                   v5_q;
  logic [DIV_Q_W-1:0]     vdv_q;
  logic [BACK_STAGES-1:0] vb_q;
  logic                   out_v_q, skid_v_q;

  logic signed [32:0] dx_w, dy_w;
  logic [31:0]        dist_w, len_w;
  logic [30:0]        nxm_w, nym_w, ca_w, cb_w;
  logic [32:0]        big_w;
  logic [4:0]         lz_w;
  logic [16:0]        rsum_w;
  logic signed [33:0] ovf_w;

  // left shift that brings the top set bit of a 31-bit value to bit 30
  function automatic logic [4:0] lead_shift(input logic [30:0] v);
    logic [4:0] s;
    s = '0;
    for (int i = 0; i < 31; i++) begin
      if (v[i]) s = 5'(30 - i);
    end
    return s;
  endfunction

  assign en         = !skid_v_q;
  assign in_ready_o = en;
  assign out_take   = !out_v_q || out_ready_i;

  // stage 1: centre difference and its magnitude
  assign dx_w = 33'(b_pos_x_i) - 33'(a_pos_x_i);
  assign dy_w = 33'(b_pos_y_i) - 33'(a_pos_y_i);

  always_comb begin
    s1_d        = '0;
    s1_d.ax     = a_pos_x_i;
    s1_d.ay     = a_pos_y_i;
    s1_d.bx     = b_pos_x_i;
    s1_d.by     = b_pos_y_i;
    s1_d.vax    = a_vel_x_i;
    s1_d.vay    = a_vel_y_i;
    s1_d.vbx    = b_vel_x_i;
    s1_d.vby    = b_vel_y_i;
    s1_d.ra     = a_radius_i;
    s1_d.rb     = b_radius_i;
    s1_d.dx_neg = dx_w[32];
    s1_d.dy_neg = dy_w[32];
    s1_d.coin   = (dx_w == '0) && (dy_w == '0);
    s1_d.ux     = dx_w[32] ? 33'(-dx_w) : 33'(dx_w);
    s1_d.uy     = dy_w[32] ? 33'(-dy_w) : 33'(dy_w);
  end

  // stage 2: squares for the distance, normalisation for the normal, masses
  assign big_w = (s1_q.ux > s1_q.uy) ? s1_q.ux : s1_q.uy;
  assign lz_w  = lead_shift(big_w[30:0]);

  always_comb begin
    s2_d     = s1_q;
    s2_d.far = (s1_q.ux[32:31] != 2'b00) || (s1_q.uy[32:31] != 2'b00);
    s2_d.ux2 = s1_q.ux[30:0] * s1_q.ux[30:0];
    s2_d.uy2 = s1_q.uy[30:0] * s1_q.uy[30:0];
    if (big_w[32:31] != 2'b00) begin
      s2_d.sx = s1_q.ux[32:1];
      s2_d.sy = s1_q.uy[32:1];
    end else begin
      s2_d.sx = s1_q.ux[31:0] << lz_w;
      s2_d.sy = s1_q.uy[31:0] << lz_w;
    end
    s2_d.ma = s1_q.ra * s1_q.ra;
    s2_d.mb = s1_q.rb * s1_q.rb;
  end

  // stage 3
  always_comb begin
    s3_d      = s2_q;
    s3_d.dsum = 63'(s2_q.ux2) + 63'(s2_q.uy2);
    s3_d.sx2  = s2_q.sx * s2_q.sx;
    s3_d.sy2  = s2_q.sy * s2_q.sy;
    s3_d.mt   = 33'(s2_q.ma) + 33'(s2_q.mb);
  end

  // stage 4
  always_comb begin
    s4_d      = s3_q;
    s4_d.lsum = s3_q.sx2 + s3_q.sy2;
    s4_d.zm   = (s3_q.mt == '0);
  end

  edcr_isqrt_pipe u_sqrt_dist (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  ({1'b0, s4_q.dsum}),
    .root_o (dist_w)
  );

  edcr_isqrt_pipe u_sqrt_len (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (s4_q.lsum),
    .root_o (len_w)
  );

  // stage 5: overlap, push flag and the four dividends
  assign rsum_w = 17'(sq_dl_q[SQ_STEPS-1].ra) + 17'(sq_dl_q[SQ_STEPS-1].rb);
  assign ovf_w  = 34'({rsum_w, 8'd0}) - 34'(dist_w);

  always_comb begin
    s5_d       = sq_dl_q[SQ_STEPS-1];
    s5_d.len   = len_w;
    s5_d.pa    = !s5_d.coin && !s5_d.far && !ovf_w[33];
    s5_d.ov    = s5_d.pa ? ovf_w[24:0] : '0;
    s5_d.num_x = (63'(s5_d.sx) << 30) + 63'(len_w >> 1);
    s5_d.num_y = (63'(s5_d.sy) << 30) + 63'(len_w >> 1);
    s5_d.num_a = (63'(s5_d.ma) << 30) + 63'(s5_d.mt >> 1);
    s5_d.num_b = (63'(s5_d.mb) << 30) + 63'(s5_d.mt >> 1);
  end

  edcr_div_pipe u_div_nx (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s5_q.num_x),
    .den_i (33'(s5_q.len)),
    .quo_o (nxm_w)
  );

  edcr_div_pipe u_div_ny (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s5_q.num_y),
    .den_i (33'(s5_q.len)),
    .quo_o (nym_w)
  );

  edcr_div_pipe u_div_ca (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s5_q.num_a),
    .den_i (s5_q.mt),
    .quo_o (ca_w)
  );

  edcr_div_pipe u_div_cb (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (s5_q.num_b),
    .den_i (s5_q.mt),
    .quo_o (cb_w)
  );

  // stage 6: signed unit normal in q2.30, mass shares in q1.30
  always_comb begin
    s6_d    = dv_dl_q[DIV_Q_W-1];
    s6_d.nx = s6_d.dx_neg ? -(32'(nxm_w)) : 32'(nxm_w);
    s6_d.ny = s6_d.dy_neg ? -(32'(nym_w)) : 32'(nym_w);
    s6_d.ca = ca_w;
    s6_d.cb = cb_w;
  end

  // stage 7: push and projection products
  always_comb begin
    s7_d       = s6_q;
    s7_d.ppx   = s6_q.nx * $signed({1'b0, s6_q.ov});
    s7_d.ppy   = s6_q.ny * $signed({1'b0, s6_q.ov});
    s7_d.p_axn = s6_q.vax * s6_q.nx;
    s7_d.p_ayn = s6_q.vay * s6_q.ny;
    s7_d.p_ayx = s6_q.vay * s6_q.nx;
    s7_d.p_axy = s6_q.vax * s6_q.ny;
    s7_d.p_bxn = s6_q.vbx * s6_q.nx;
    s7_d.p_byn = s6_q.vby * s6_q.ny;
    s7_d.p_byx = s6_q.vby * s6_q.nx;
    s7_d.p_bxy = s6_q.vbx * s6_q.ny;
  end

  // stage 8: dot products, half-overlap push
  always_comb begin
    s8_d        = s7_q;
    s8_d.sum_an = 65'(s7_q.p_axn) + 65'(s7_q.p_ayn);
    s8_d.sum_at = 65'(s7_q.p_ayx) - 65'(s7_q.p_axy);
    s8_d.sum_bn = 65'(s7_q.p_bxn) + 65'(s7_q.p_byn);
    s8_d.sum_bt = 65'(s7_q.p_byx) - 65'(s7_q.p_bxy);
    s8_d.px     = 26'(rshr(RW'(s7_q.ppx), 31));
    s8_d.py     = 26'(rshr(RW'(s7_q.ppy), 31));
  end

  // stage 9: normal and tangent speeds, separated centres
  always_comb begin
    s9_d     = s8_q;
    s9_d.van = 35'(rshr(RW'(s8_q.sum_an), 30));
    s9_d.vat = 35'(rshr(RW'(s8_q.sum_at), 30));
    s9_d.vbn = 35'(rshr(RW'(s8_q.sum_bn), 30));
    s9_d.vbt = 35'(rshr(RW'(s8_q.sum_bt), 30));
    if (s8_q.pa) begin
      s9_d.nax = 34'(s8_q.ax) - 34'(s8_q.px);
      s9_d.nay = 34'(s8_q.ay) - 34'(s8_q.py);
      s9_d.nbx = 34'(s8_q.bx) + 34'(s8_q.px);
      s9_d.nby = 34'(s8_q.by) + 34'(s8_q.py);
    end else begin
      s9_d.nax = 34'(s8_q.ax);
      s9_d.nay = 34'(s8_q.ay);
      s9_d.nbx = 34'(s8_q.bx);
      s9_d.nby = 34'(s8_q.by);
    end
  end

  // stage 10
  always_comb begin
    s10_d     = s9_q;
    s10_d.dba = 36'(s9_q.vbn) - 36'(s9_q.van);
    s10_d.dab = 36'(s9_q.van) - 36'(s9_q.vbn);
  end

  // stage 11: share times speed difference
  always_comb begin
    s11_d    = s10_q;
    s11_d.ta = $signed({1'b0, s10_q.cb}) * s10_q.dba;
    s11_d.tb = $signed({1'b0, s10_q.ca}) * s10_q.dab;
  end

  // stage 12
  always_comb begin
    s12_d    = s11_q;
    s12_d.ea = 40'(rshr(RW'(s11_q.ta), 29));
    s12_d.eb = 40'(rshr(RW'(s11_q.tb), 29));
  end

  // stage 13: new normal speeds, clamped
  always_comb begin
    s13_d     = s12_q;
    s13_d.nan = clampn(41'(s12_q.van) + 41'(s12_q.ea));
    s13_d.nbn = clampn(41'(s12_q.vbn) + 41'(s12_q.eb));
  end

  // stage 14: rebuild products
  always_comb begin
    s14_d     = s13_q;
    s14_d.qa1 = s13_q.nan * s13_q.nx;
    s14_d.qa2 = s13_q.vat * s13_q.ny;
    s14_d.qa3 = s13_q.nan * s13_q.ny;
    s14_d.qa4 = s13_q.vat * s13_q.nx;
    s14_d.qb1 = s13_q.nbn * s13_q.nx;
    s14_d.qb2 = s13_q.vbt * s13_q.ny;
    s14_d.qb3 = s13_q.nbn * s13_q.ny;
    s14_d.qb4 = s13_q.vbt * s13_q.nx;
  end

  // stage 15
  always_comb begin
    s15_d      = s14_q;
    s15_d.wsax = 68'(s14_q.qa1) - 68'(s14_q.qa2);
    s15_d.wsay = 68'(s14_q.qa3) + 68'(s14_q.qa4);
    s15_d.wsbx = 68'(s14_q.qb1) - 68'(s14_q.qb2);
    s15_d.wsby = 68'(s14_q.qb3) + 68'(s14_q.qb4);
  end

  // stage 16
  always_comb begin
    s16_d     = s15_q;
    s16_d.wax = 38'(rshr(RW'(s15_q.wsax), 30));
    s16_d.way = 38'(rshr(RW'(s15_q.wsay), 30));
    s16_d.wbx = 38'(rshr(RW'(s15_q.wsbx), 30));
    s16_d.wby = 38'(rshr(RW'(s15_q.wsby), 30));
  end

  // stage 17: saturation and the special cases
  always_comb begin
    s17_d.pa = s16_q.pa;
    if (s16_q.coin) begin
      // coincident centres: everything passes through
      s17_d.ax      = s16_q.ax;
      s17_d.ay      = s16_q.ay;
      s17_d.bx      = s16_q.bx;
      s17_d.by      = s16_q.by;
      s17_d.vax     = s16_q.vax;
      s17_d.vay     = s16_q.vay;
      s17_d.vbx     = s16_q.vbx;
      s17_d.vby     = s16_q.vby;
      s17_d.outcome = OUT_COINCIDENT;
    end else begin
      s17_d.ax = sat32(RW'(s16_q.nax));
      s17_d.ay = sat32(RW'(s16_q.nay));
      s17_d.bx = sat32(RW'(s16_q.nbx));
      s17_d.by = sat32(RW'(s16_q.nby));
      if (s16_q.zm) begin
        // both radii zero: velocities pass through
        s17_d.vax     = s16_q.vax;
        s17_d.vay     = s16_q.vay;
        s17_d.vbx     = s16_q.vbx;
        s17_d.vby     = s16_q.vby;
        s17_d.outcome = OUT_ZERO_MASS;
      end else begin
        s17_d.vax     = sat32(RW'(s16_q.wax));
        s17_d.vay     = sat32(RW'(s16_q.way));
        s17_d.vbx     = sat32(RW'(s16_q.wbx));
        s17_d.vby     = sat32(RW'(s16_q.wby));
        s17_d.outcome = OUT_RESOLVED;
      end
    end
  end

  // valid bits travel alongside the payload
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vf_q  <= '0;
      vsq_q <= '0;
      v5_q  <= 1'b0;
      vdv_q <= '0;
      vb_q  <= '0;
    end else if (en) begin
      vf_q  <= {vf_q[2:0], in_valid_i};
      vsq_q <= {vsq_q[SQ_STEPS-2:0], vf_q[3]};
      v5_q  <= vsq_q[SQ_STEPS-1];
      vdv_q <= {vdv_q[DIV_Q_W-2:0], v5_q};
      vb_q  <= {vb_q[BACK_STAGES-2:0], vdv_q[DIV_Q_W-1]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_q <= s1_d;
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
      sq_dl_q[0] <= s4_q;
      for (int k = 1; k < SQ_STEPS; k++) begin
        sq_dl_q[k] <= sq_dl_q[k-1];
      end
      s5_q <= s5_d;
      dv_dl_q[0] <= s5_q;
      for (int k = 1; k < DIV_Q_W; k++) begin
        dv_dl_q[k] <= dv_dl_q[k-1];
      end
      s6_q  <= s6_d;
      s7_q  <= s7_d;
      s8_q  <= s8_d;
      s9_q  <= s9_d;
      s10_q <= s10_d;
      s11_q <= s11_d;
      s12_q <= s12_d;
      s13_q <= s13_d;
      s14_q <= s14_d;
      s15_q <= s15_d;
      s16_q <= s16_d;
      s17_q <= s17_d;
    end
  end

  // output register plus skid stage: a result leaving the pipe while the output
  // is held parks in the skid stage, which then freezes the pipe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (out_take) begin
      if (skid_v_q) begin
        out_v_q  <= 1'b1;
        skid_v_q <= 1'b0;
      end else begin
        out_v_q <= vb_q[BACK_STAGES-1];
      end
    end else if (en && vb_q[BACK_STAGES-1]) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_take) begin
      out_q <= skid_v_q ? skid_q : s17_q;
    end else if (en && vb_q[BACK_STAGES-1]) begin
      skid_q <= s17_q;
    end
  end

  assign out_valid_o    = out_v_q;
  assign new_a_pos_x_o  = out_q.ax;
  assign new_a_pos_y_o  = out_q.ay;
  assign new_b_pos_x_o  = out_q.bx;
  assign new_b_pos_y_o  = out_q.by;
  assign new_a_vel_x_o  = out_q.vax;
  assign new_a_vel_y_o  = out_q.vay;
  assign new_b_vel_x_o  = out_q.vbx;
  assign new_b_vel_y_o  = out_q.vby;
  assign pushed_apart_o = out_q.pa;
  assign outcome_o      = out_q.outcome;

`ifndef ASSERT_OFF
  // the skid stage only ever holds a second result behind a full output register
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_v_q |-> out_v_q)
    else $error("skid stage full while output register empty");

  // the skid stage fills only when the output was held
  a_skid_fill_on_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(skid_v_q) |-> $past(out_v_q && !out_ready_i))
    else $error("skid stage filled without an output stall");

  // a push needs distinct centres and at least one nonzero radius
  a_push_resolved: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && pushed_apart_o) |-> (outcome_o == OUT_RESOLVED))
    else $error("push flagged on an unresolved pair");
`endif

endmodule

// ----- design/edcr_isqrt_pipe.sv -----
module edcr_isqrt_pipe import edcr_pkg::*; (
  input  logic                clk_i,
  input  logic                en_i,
  input  logic [SQ_IN_W-1:0]  rad_i,
  output logic [SQ_OUT_W-1:0] root_o
);

  logic [SQ_IN_W-1:0] x_q [SQ_STEPS];
  logic [SQ_IN_W-1:0] r_q [SQ_STEPS];

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    logic [SQ_IN_W-1:0] x_in, r_in, bit_v, trial;
    if (k == 0) begin : g_first
      assign x_in = rad_i;
      assign r_in = '0;
    end else begin : g_next
      assign x_in = x_q[k-1];
      assign r_in = r_q[k-1];
    end
    assign bit_v = SQ_IN_W'(1) << (SQ_IN_W - 2 - 2 * k);
    assign trial = r_in + bit_v;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (x_in >= trial) begin
          x_q[k] <= x_in - trial;
          r_q[k] <= (r_in >> 1) + bit_v;
        end else begin
          x_q[k] <= x_in;
          r_q[k] <= r_in >> 1;
        end
      end
    end
  end

  assign root_o = r_q[SQ_STEPS-1][SQ_OUT_W-1:0];

endmodule

// ----- design/edcr_div_pipe.sv -----
module edcr_div_pipe import edcr_pkg::*; (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [DIV_NUM_W-1:0] num_i,
  input  logic [DIV_DEN_W-1:0] den_i,
  output logic [DIV_Q_W-1:0]   quo_o
);

  logic [DIV_DEN_W-1:0] rem_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   low_q [DIV_Q_W];
  logic [DIV_Q_W-1:0]   quo_q [DIV_Q_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_Q_W];

  for (genvar k = 0; k < DIV_Q_W; k++) begin : g_step
    logic [DIV_DEN_W-1:0] rem_in, den_in;
    logic [DIV_Q_W-1:0]   low_in, quo_in;
    logic [DIV_DEN_W:0]   trial;
    logic                 ge;
    if (k == 0) begin : g_first
      assign rem_in = DIV_DEN_W'(num_i[DIV_NUM_W-1:DIV_Q_W]);
      assign low_in = num_i[DIV_Q_W-1:0];
      assign quo_in = '0;
      assign den_in = den_i;
    end else begin : g_next
      assign rem_in = rem_q[k-1];
      assign low_in = low_q[k-1];
      assign quo_in = quo_q[k-1];
      assign den_in = den_q[k-1];
    end
    assign trial = {rem_in, low_in[DIV_Q_W-1]};
    assign ge    = trial >= {1'b0, den_in};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= ge ? DIV_DEN_W'(trial - {1'b0, den_in}) : DIV_DEN_W'(trial);
        low_q[k] <= low_in << 1;
        quo_q[k] <= {quo_in[DIV_Q_W-2:0], ge};
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_o = quo_q[DIV_Q_W-1];

endmodule

// ----- test/tb_elastic_disk_collision_response.sv -----
module tb_elastic_disk_collision_response;
  import edcr_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // one disk pair as it enters the block
  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by;
    logic signed [31:0] vax, vay, vbx, vby;
    logic        [15:0] ra, rb;
  } disk_pair_t;

  // one contact result as it leaves the block
  typedef struct packed {
    logic signed [31:0] ax, ay, bx, by;
    logic signed [31:0] vax, vay, vbx, vby;
    logic               pushed;
    outcome_e           outcome;
  } contact_t;

  // wide signed working type, roomy enough that no product can wrap
  typedef logic signed [127:0] wide_t;

  localparam int HOLD_CYCLES = 400;
  localparam int STALL_LIMIT = 4000;

  logic clk_i;
  logic rst_ni;

  logic               in_valid_i;
  logic               in_ready_o;
  logic signed [31:0] a_pos_x_i, a_pos_y_i, b_pos_x_i, b_pos_y_i;
  logic signed [31:0] a_vel_x_i, a_vel_y_i, b_vel_x_i, b_vel_y_i;
  logic        [15:0] a_radius_i, b_radius_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic signed [31:0] new_a_pos_x_o, new_a_pos_y_o, new_b_pos_x_o, new_b_pos_y_o;
  logic signed [31:0] new_a_vel_x_o, new_a_vel_y_o, new_b_vel_x_o, new_b_vel_y_o;
  logic               pushed_apart_o;
  logic        [1:0]  outcome_o;

  elastic_disk_collision_response i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .a_pos_x_i      (a_pos_x_i),
    .a_pos_y_i      (a_pos_y_i),
    .b_pos_x_i      (b_pos_x_i),
    .b_pos_y_i      (b_pos_y_i),
    .a_vel_x_i      (a_vel_x_i),
    .a_vel_y_i      (a_vel_y_i),
    .b_vel_x_i      (b_vel_x_i),
    .b_vel_y_i      (b_vel_y_i),
    .a_radius_i     (a_radius_i),
    .b_radius_i     (b_radius_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .new_a_pos_x_o  (new_a_pos_x_o),
    .new_a_pos_y_o  (new_a_pos_y_o),
    .new_b_pos_x_o  (new_b_pos_x_o),
    .new_b_pos_y_o  (new_b_pos_y_o),
    .new_a_vel_x_o  (new_a_vel_x_o),
    .new_a_vel_y_o  (new_a_vel_y_o),
    .new_b_vel_x_o  (new_b_vel_x_o),
    .new_b_vel_y_o  (new_b_vel_y_o),
    .pushed_apart_o (pushed_apart_o),
    .outcome_o      (outcome_o)
  );

  // results still owed by the block, oldest first
  contact_t pending_contacts[$];

  int mismatches;
  int pairs_sent;
  int contacts_seen;
  int pushes_seen;
  int coincident_seen;
  int massless_seen;
  int send_idle_pct;  // chance in percent of an idle cycle on the sending side
  int recv_idle_pct;  // chance in percent of ready low in a cycle
  int hold_requests;  // bumped by a test to ask the receiver for a long hold-off

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // divide by 2^sh, rounding half away from zero
  function automatic wide_t round_shift(wide_t v, int sh);
    wide_t m;
    m = (v < 0) ? -v : v;
    m = (m + (wide_t'(1) <<< (sh - 1))) >>> sh;
    return (v < 0) ? -m : m;
  endfunction

  // floor square root, digit by digit
  function automatic logic [63:0] floor_sqrt(logic [63:0] x);
    logic [63:0] root;
    logic [63:0] bitv;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= root + bitv) begin
        x    = x - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root;
  endfunction

  function automatic logic signed [31:0] clip32(wide_t v);
    if (v > 128'sd2147483647) return 32'sh7fffffff;
    if (v < -128'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  // limit a new normal speed to +-65536.0
  function automatic wide_t clip_normal(wide_t v);
    wide_t lim;
    lim = wide_t'(1) <<< 32;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic contact_t predict_contact(disk_pair_t p);
    contact_t r;
    wide_t ax, ay, bx, by, dx, dy, ux, uy, big, len, nx, ny, ovl;
    wide_t ma, mb, msum, van, vat, vbn, vbt, ca, cb, nan_a, nbn, px, py;
    logic [63:0] centre_gap;
    logic push;
    ax = p.ax; ay = p.ay; bx = p.bx; by = p.by;
    r.ax = p.ax; r.ay = p.ay; r.bx = p.bx; r.by = p.by;
    r.vax = p.vax; r.vay = p.vay; r.vbx = p.vbx; r.vby = p.vby;
    r.pushed = 1'b0;
    r.outcome = OUT_RESOLVED;
    dx = bx - ax;
    dy = by - ay;
    if (dx == 0 && dy == 0) begin
      r.outcome = OUT_COINCIDENT;
      return r;
    end
    ux = (dx < 0) ? -dx : dx;
    uy = (dy < 0) ? -dy : dy;
    push = 1'b0;
    ovl = 0;
    // far apart on either axis means no overlap is possible
    if (ux < (wide_t'(1) <<< 31) && uy < (wide_t'(1) <<< 31)) begin
      centre_gap = floor_sqrt(64'(ux * ux + uy * uy));
      ovl = ((wide_t'(p.ra) + wide_t'(p.rb)) <<< 8) - wide_t'(centre_gap);
      push = (ovl >= 0);
    end
    // unit normal in q2.30 from the scaled direction
    big = (ux > uy) ? ux : uy;
    if (big >= (wide_t'(1) <<< 31)) begin
      ux = ux >>> 1;
      uy = uy >>> 1;
    end else begin
      while (big < (wide_t'(1) <<< 30)) begin
        big = big <<< 1;
        ux = ux <<< 1;
        uy = uy <<< 1;
      end
    end
    len = wide_t'(floor_sqrt(64'(ux * ux + uy * uy)));
    nx = ((ux <<< 30) + len / 2) / len;
    ny = ((uy <<< 30) + len / 2) / len;
    if (dx < 0) nx = -nx;
    if (dy < 0) ny = -ny;
    if (push) begin
      px = round_shift(nx * ovl, 31);
      py = round_shift(ny * ovl, 31);
      r.ax = clip32(ax - px);
      r.ay = clip32(ay - py);
      r.bx = clip32(bx + px);
      r.by = clip32(by + py);
      r.pushed = 1'b1;
    end
    ma = wide_t'(p.ra) * wide_t'(p.ra);
    mb = wide_t'(p.rb) * wide_t'(p.rb);
    msum = ma + mb;
    if (msum == 0) begin
      r.outcome = OUT_ZERO_MASS;
      return r;
    end
    van = round_shift(wide_t'(p.vax) * nx + wide_t'(p.vay) * ny, 30);
    vat = round_shift(wide_t'(p.vay) * nx - wide_t'(p.vax) * ny, 30);
    vbn = round_shift(wide_t'(p.vbx) * nx + wide_t'(p.vby) * ny, 30);
    vbt = round_shift(wide_t'(p.vby) * nx - wide_t'(p.vbx) * ny, 30);
    ca = ((ma <<< 30) + msum / 2) / msum;
    cb = ((mb <<< 30) + msum / 2) / msum;
    // 1-d elastic exchange of the normal parts, tangent parts kept
    nan_a = clip_normal(van + round_shift(cb * (vbn - van), 29));
    nbn = clip_normal(vbn + round_shift(ca * (van - vbn), 29));
    r.vax = clip32(round_shift(nan_a * nx - vat * ny, 30));
    r.vay = clip32(round_shift(nan_a * ny + vat * nx, 30));
    r.vbx = clip32(round_shift(nbn * nx - vbt * ny, 30));
    r.vby = clip32(round_shift(nbn * ny + vbt * nx, 30));
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    rst_ni = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // ---------------------------------------------------------------------------
  // sender: offers one pair, holds it until the transaction completes
  // ---------------------------------------------------------------------------

  // called at a rising edge; valid stays high on return unless a gap was taken
  task automatic send_pair(disk_pair_t p);
    in_valid_i <= 1'b1;
    a_pos_x_i  <= p.ax;
    a_pos_y_i  <= p.ay;
    b_pos_x_i  <= p.bx;
    b_pos_y_i  <= p.by;
    a_vel_x_i  <= p.vax;
    a_vel_y_i  <= p.vay;
    b_vel_x_i  <= p.vbx;
    b_vel_y_i  <= p.vby;
    a_radius_i <= p.ra;
    b_radius_i <= p.rb;
    do @(posedge clk_i); while (!in_ready_o);
    // transaction taken at this edge, so the prediction is owed from now on
    pending_contacts.push_back(predict_contact(p));
    pairs_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
  endtask

  // ---------------------------------------------------------------------------
  // stimulus shapes
  // ---------------------------------------------------------------------------

  function automatic logic signed [31:0] any_word();
    logic [31:0] w;
    w = $urandom;
    case ($urandom_range(7))
      0: w = 32'h7fffffff;
      1: w = 32'h80000000;
      2: w = w >> $urandom_range(31);
      default: ;
    endcase
    return w;
  endfunction

  // a pair close enough to touch most of the time, with random content
  function automatic disk_pair_t near_pair();
    disk_pair_t p;
    int spread;
    spread = 1 << $urandom_range(12, 22);
    p.ax  = $urandom;
    p.ay  = $urandom;
    p.bx  = p.ax + $signed($urandom_range(0, 2 * spread)) - spread;
    p.by  = p.ay + $signed($urandom_range(0, 2 * spread)) - spread;
    p.ra  = 16'($urandom_range(0, 1 << $urandom_range(6, 14)));
    p.rb  = 16'($urandom_range(0, 1 << $urandom_range(6, 14)));
    p.vax = $signed($urandom) >>> $urandom_range(0, 14);
    p.vay = $signed($urandom) >>> $urandom_range(0, 14);
    p.vbx = $signed($urandom) >>> $urandom_range(0, 14);
    p.vby = $signed($urandom) >>> $urandom_range(0, 14);
    return p;
  endfunction

  function automatic disk_pair_t wild_pair();
    disk_pair_t p;
    p.ax = any_word(); p.ay = any_word(); p.bx = any_word(); p.by = any_word();
    p.vax = any_word(); p.vay = any_word(); p.vbx = any_word(); p.vby = any_word();
    p.ra = 16'($urandom);
    p.rb = 16'($urandom);
    return p;
  endfunction

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  task automatic test_directed();
    disk_pair_t p;
    // coincident centres, velocities must pass through
    p = '{32'sh10000, 32'sh20000, 32'sh10000, 32'sh20000,
          32'sh1000, -32'sh1000, 32'sh7fffffff, 32'sh80000000, 16'h0100, 16'h0200};
    send_pair(p);
    // coincident at both extremes with huge radii
    p = '{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
          32'sh80000000, 32'sh7fffffff, 32'sh0, 32'sh1, 16'hffff, 16'hffff};
    send_pair(p);
    // zero total mass, centres close together but not overlapping
    p = '{32'sh0, 32'sh0, 32'sh100, 32'sh0, 32'sh10000, 32'sh0, -32'sh10000, 32'sh0,
          16'h0, 16'h0};
    send_pair(p);
    // head-on equal masses along x, overlapping: velocities swap
    p = '{32'sh0, 32'sh0, 32'sh18000, 32'sh0, 32'sh10000, 32'sh0, -32'sh20000, 32'sh0,
          16'h0100, 16'h0100};
    send_pair(p);
    // exactly touching: overlap zero still pushes
    p = '{32'sh0, 32'sh0, 32'sh20000, 32'sh0, 32'sh0, 32'sh10000, 32'sh0, 32'sh0,
          16'h0100, 16'h0100};
    send_pair(p);
    // apart along a diagonal: no push but velocities resolved
    p = '{32'sh0, 32'sh0, 32'sh50000, -32'sh50000, 32'sh30000, 32'sh0, 32'sh0,
          -32'sh30000, 16'h0080, 16'h0300};
    send_pair(p);
    // one massless disk meeting a heavy one
    p = '{-32'sh40000, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0, -32'sh50000, 32'sh0,
          16'h0000, 16'h0400};
    send_pair(p);
    // centres at opposite extremes: distance far beyond 2^31
    p = '{32'sh80000000, 32'sh80000000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh7fffffff, 32'sh7fffffff, 32'sh80000000, 32'sh80000000, 16'hffff, 16'hffff};
    send_pair(p);
    // one axis far, other zero
    p = '{32'sh80000000, 32'sh0, 32'sh7fffffff, 32'sh0,
          32'sh12345678, -32'sh1234567, 32'sh0, 32'sh7654321, 16'h1000, 16'h0001};
    send_pair(p);
    // huge opposing normal speeds: new normal speed is clamped
    p = '{32'sh0, 32'sh0, 32'sh10000, 32'sh10000, 32'sh7fffffff, 32'sh7fffffff,
          32'sh80000000, 32'sh80000000, 16'h0001, 16'hffff};
    send_pair(p);
    // smallest separation with largest radii: push saturates positions
    p = '{32'sh7ffffff0, 32'sh0, 32'sh7fffffff, 32'sh0, 32'sh0, 32'sh0, 32'sh0, 32'sh0,
          16'hffff, 16'hffff};
    send_pair(p);
    p = '{32'sh80000000, 32'sh80000000, 32'sh80000001, 32'sh80000001,
          32'sh1, -32'sh1, 32'sh0, 32'sh0, 16'hffff, 16'h0001};
    send_pair(p);
    // all ones and all zeros on the radii with tiny offsets
    p = '{-32'sh1, -32'sh1, 32'sh0, 32'sh0, -32'sh1, 32'sh0, 32'sh0, -32'sh1,
          16'hffff, 16'h0000};
    send_pair(p);
  endtask

  task automatic test_random(int n);
    repeat (n) begin
      if ($urandom_range(99) < 75) send_pair(near_pair());
      else send_pair(wild_pair());
    end
  endtask

  // receiver holds off while pairs keep coming, so the block backs up
  task automatic test_backpressure(int n);
    send_idle_pct = 0;
    hold_requests++;
    repeat (n) send_pair(near_pair());
    send_idle_pct = 33;
  endtask

  // ---------------------------------------------------------------------------
  // receiver, result check and watchdog
  // ---------------------------------------------------------------------------

  initial begin
    contact_t got, want;
    int hold_left;
    int holds_seen;
    int quiet;
    hold_left = 0;
    holds_seen = 0;
    quiet = 0;
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni) begin
        if (out_valid_o && out_ready_i) begin
          got = '{new_a_pos_x_o, new_a_pos_y_o, new_b_pos_x_o, new_b_pos_y_o,
                  new_a_vel_x_o, new_a_vel_y_o, new_b_vel_x_o, new_b_vel_y_o,
                  pushed_apart_o, outcome_e'(outcome_o)};
          contacts_seen++;
          if (pending_contacts.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result %p", got);
          end else begin
            want = pending_contacts.pop_front();
            if (got.pushed) pushes_seen++;
            if (got.outcome == OUT_COINCIDENT) coincident_seen++;
            if (got.outcome == OUT_ZERO_MASS) massless_seen++;
            if (got !== want) begin
              mismatches++;
              if (mismatches <= 10) begin
                $display("mismatch on result %0d", contacts_seen);
                $display("  expected %p", want);
                $display("  actual   %p", got);
              end
            end
          end
        end
        // watchdog on cycles with no transaction on either side
        if ((out_valid_o && out_ready_i) || (in_valid_i && in_ready_o)) quiet = 0;
        else quiet++;
        if (quiet >= STALL_LIMIT) begin
          $display("no progress for %0d cycles", STALL_LIMIT);
          $display("CHECK FAILED");
          $finish;
        end
      end
      if (hold_requests != holds_seen) begin
        holds_seen = hold_requests;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ready_i <= 1'b0;
      end else begin
        out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    int waited;
    in_valid_i <= 1'b0;
    a_pos_x_i <= '0; a_pos_y_i <= '0; b_pos_x_i <= '0; b_pos_y_i <= '0;
    a_vel_x_i <= '0; a_vel_y_i <= '0; b_vel_x_i <= '0; b_vel_y_i <= '0;
    a_radius_i <= '0; b_radius_i <= '0;
    mismatches = 0;
    pairs_sent = 0;
    contacts_seen = 0;
    pushes_seen = 0;
    coincident_seen = 0;
    massless_seen = 0;
    hold_requests = 0;
    send_idle_pct = 33;
    recv_idle_pct = 33;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);

    test_directed();
    test_random(350);
    // a long stretch with no idling on either side
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random(300);
    send_idle_pct = 33;
    recv_idle_pct = 33;
    test_backpressure(200);
    test_random(200);
    in_valid_i <= 1'b0;

    waited = 0;
    while (pending_contacts.size() != 0 && waited < STALL_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    repeat (120) @(posedge clk_i);

    $display("sent %0d disk pairs, checked %0d results", pairs_sent, contacts_seen);
    $display("pushed apart %0d, coincident %0d, massless %0d, mismatches %0d",
             pushes_seen, coincident_seen, massless_seen, mismatches);
    if (mismatches == 0 && pending_contacts.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/edcr_pkg.sv
design/edcr_isqrt_pipe.sv
design/edcr_div_pipe.sv
design/elastic_disk_collision_response.sv
test/tb_elastic_disk_collision_response.sv
